// File: rtl/iwc_pkg.sv
// ----------------------------------------------------------------------------
// iwc_pkg
// Shared types and fixed widths for the intensity weighted centroid block.
// ----------------------------------------------------------------------------
package iwc_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int MASS_W    = 32;
    localparam int MOM_W     = 45;
    localparam int COORD_W   = 20;
    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET = 13'd1024;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               empty_frame;
    } t_result;

    // sums of one finished frame, handed from accumulator to divider
    typedef struct packed {
        logic [MASS_W-1:0] mass_sum;
        logic [MOM_W-1:0]  x_moment_sum;
        logic [MOM_W-1:0]  y_moment_sum;
    } t_frame;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_div_state;

endpackage

// File: rtl/iwc_accum.sv
// ----------------------------------------------------------------------------
// iwc_accum
// Front end: tracks pixel position and accumulates mass and moment sums;
// pushes the frame sums on the last pixel and clears for the next frame.
// ----------------------------------------------------------------------------
module iwc_accum import iwc_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_pixel           i_pixel,
    input  logic             i_q_full,
    output logic             o_q_push,
    output t_frame           o_q_frame
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (WMAX_W > CFG_W) ? WMAX_W : CFG_W;
    localparam int PROD_W = PIX_W + ((COL_W > ROW_W) ? COL_W : ROW_W);

    logic [CFG_W-1:0]  r_width;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [MASS_W-1:0] r_mass;
    logic [MOM_W-1:0]  r_xm;
    logic [MOM_W-1:0]  r_ym;

    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [MASS_W-1:0] n_mass;
    logic [MOM_W-1:0]  n_xm;
    logic [MOM_W-1:0]  n_ym;

    logic              w_accept;
    logic [WCMP_W-1:0] w_eff_width;
    logic [WCMP_W-1:0] w_col_inc;
    logic [MASS_W:0]   w_mass_add;
    logic [PROD_W-1:0] w_xprod;
    logic [PROD_W-1:0] w_yprod;
    logic [MOM_W:0]    w_xm_add;
    logic [MOM_W:0]    w_ym_add;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    always_comb begin
        w_eff_width = WCMP_W'(r_width);
        if (r_width == '0) begin
            w_eff_width = WCMP_W'(1);
        end
        if (w_eff_width > WCMP_W'(MAX_WIDTH)) begin
            w_eff_width = WCMP_W'(MAX_WIDTH);
        end

        w_xprod    = PROD_W'(i_pixel.pixel_value) * PROD_W'(r_col);
        w_yprod    = PROD_W'(i_pixel.pixel_value) * PROD_W'(r_row);
        w_mass_add = {1'b0, r_mass} + (MASS_W+1)'(i_pixel.pixel_value);
        w_xm_add   = {1'b0, r_xm} + (MOM_W+1)'(w_xprod);
        w_ym_add   = {1'b0, r_ym} + (MOM_W+1)'(w_yprod);

        // saturating sums
        n_mass = w_mass_add[MASS_W] ? '1 : w_mass_add[MASS_W-1:0];
        n_xm   = w_xm_add[MOM_W]    ? '1 : w_xm_add[MOM_W-1:0];
        n_ym   = w_ym_add[MOM_W]    ? '1 : w_ym_add[MOM_W-1:0];

        w_col_inc = WCMP_W'(r_col) + WCMP_W'(1);
        n_col     = w_col_inc[COL_W-1:0];
        n_row     = r_row;
        if (w_col_inc >= w_eff_width) begin
            n_col = '0;
            if (r_row != ROW_W'(MAX_HEIGHT - 1)) begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    assign o_q_push                = w_accept && i_pixel.last_pixel;
    assign o_q_frame.mass_sum      = n_mass;
    assign o_q_frame.x_moment_sum  = n_xm;
    assign o_q_frame.y_moment_sum  = n_ym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_mass <= '0;
            r_xm   <= '0;
            r_ym   <= '0;
        end else if (w_accept) begin
            if (i_pixel.last_pixel) begin
                r_col  <= '0;
                r_row  <= '0;
                r_mass <= '0;
                r_xm   <= '0;
                r_ym   <= '0;
            end else begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_mass <= n_mass;
                r_xm   <= n_xm;
                r_ym   <= n_ym;
            end
        end
    end

endmodule

// File: rtl/iwc_fifo.sv
// ----------------------------------------------------------------------------
// iwc_fifo
// Two-entry queue of finished frame sums between accumulator and divider.
// ----------------------------------------------------------------------------
module iwc_fifo import iwc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_not_empty,
    output t_frame o_frame
);

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_frame     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/iwc_div.sv
// ----------------------------------------------------------------------------
// iwc_div
// Back end: radix-2 restoring division of both moments by the mass, one
// quotient bit per cycle in two lanes, with saturation and a result register.
// ----------------------------------------------------------------------------
module iwc_div import iwc_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_frm_valid,
    input  t_frame  i_frm,
    output logic    o_frm_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    localparam int DIV_W = MOM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    t_div_state        r_state;
    t_div_state        n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [MASS_W-1:0] r_mass;
    logic              r_empty;
    logic              r_out_valid;
    t_result           r_result;

    logic                        w_load_out;
    logic [1:0][MOM_W-1:0]       w_moment;
    logic [1:0][COORD_W-1:0]     w_coord;

    assign w_moment[0] = i_frm.x_moment_sum;
    assign w_moment[1] = i_frm.y_moment_sum;

    always_comb begin
        n_state    = r_state;
        o_frm_pop  = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_frm_valid) begin
                    o_frm_pop = 1'b1;
                    n_state   = (i_frm.mass_sum == '0) ? S_HOLD : S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                // result slot free or being emptied this cycle
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_frm_pop) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frm_pop) begin
            r_mass  <= i_frm.mass_sum;
            r_empty <= (i_frm.mass_sum == '0);
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [DIV_W-1:0]   r_dvd;
        logic [MASS_W-1:0]  r_rem;
        logic [COORD_W-1:0] r_quo;
        logic               r_ovf;
        logic [MASS_W:0]    w_shift;
        logic [MASS_W:0]    w_diff;
        logic               w_bit;

        assign w_shift = {r_rem, r_dvd[DIV_W-1]};
        assign w_diff  = w_shift - {1'b0, r_mass};
        assign w_bit   = (w_shift >= {1'b0, r_mass});

        always_ff @(posedge i_clk) begin
            if (o_frm_pop) begin
                r_dvd <= DIV_W'(w_moment[g]) << FRAC_BITS;
                r_rem <= '0;
                r_quo <= '0;
                r_ovf <= 1'b0;
            end else if (r_state == S_DIV) begin
                r_dvd <= r_dvd << 1;
                r_rem <= w_bit ? w_diff[MASS_W-1:0] : w_shift[MASS_W-1:0];
                r_quo <= {r_quo[COORD_W-2:0], w_bit};
                // a one shifted past the top means the coordinate saturates
                r_ovf <= r_ovf | r_quo[COORD_W-1];
            end
        end

        assign w_coord[g] = r_ovf ? '1 : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_result.center_x    <= w_coord[0];
            r_result.center_y    <= w_coord[1];
            r_result.empty_frame <= r_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// File: rtl/intensity_weighted_centroid.sv
// ----------------------------------------------------------------------------
// intensity_weighted_centroid
// First-order moment centroid of a raster-order grayscale frame.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock while the frame queue has room. The
// pixel marked last closes the frame: its sums enter a two-entry queue and a
// divider computes both coordinates in parallel, one quotient bit per cycle;
// a frame with zero mass skips the division. The divider takes no new frame
// until the last result is in the result register, so it sets the frame rate:
// back-to-back frames shorter than a division fill the queue and stall the
// input.
// Coordinates are unsigned with FRAC_BITS fraction bits and saturate at the
// top of their 20-bit range; image width must be written through the config
// port only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module intensity_weighted_centroid import iwc_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_pixel           i_pixel,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_result          o_result
);

    logic   w_q_push;
    logic   w_q_full;
    logic   w_q_pop;
    logic   w_q_not_empty;
    t_frame w_push_frame;
    t_frame w_pop_frame;

    iwc_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_frame   (w_push_frame)
    );

    iwc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_frame     (w_push_frame),
        .o_full      (w_q_full),
        .i_pop       (w_q_pop),
        .o_not_empty (w_q_not_empty),
        .o_frame     (w_pop_frame)
    );

    iwc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frm_valid (w_q_not_empty),
        .i_frm       (w_pop_frame),
        .o_frm_pop   (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

endmodule

// File: tb/sv/intensity_weighted_centroid_tb.sv
// ----------------------------------------------------------------------------
// intensity_weighted_centroid_tb
// Self-checking bench for the intensity weighted centroid block.
// ----------------------------------------------------------------------------
// A queue-fed driver streams pixels into the block and an in-bench moment
// accumulator predicts the centroid of every closed frame. A monitor checks
// each result transfer in order against those predictions. Stimulus opens
// with hand-picked frames, then runs random frames under random image
// widths with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module intensity_weighted_centroid_tb;
    import iwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS     = 4096;
    localparam int MAX_ROWS     = 4096;
    localparam int FRAC         = 8;
    localparam int RANDOM_ITEMS = 790;
    localparam int DRAIN_CYCLES = 70;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int IDLE_PCT     = 18;
    localparam int MAX_REPORTS  = 10;

    localparam logic [63:0] MASS_MAX  = 64'hFFFF_FFFF;
    localparam logic [63:0] MOM_MAX   = (64'd1 << MOM_W) - 64'd1;
    localparam logic [63:0] COORD_MAX = (64'd1 << COORD_W) - 64'd1;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    logic [CFG_W-1:0] cfg_wdata   = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    t_pixel           in_pixel    = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    t_result          out_result;

    t_pixel  pending_pixels[$];
    t_result expected_centroids[$];

    // moment accumulator state of the bench
    logic [CFG_W-1:0]  width_cfg = CFG_WIDTH_RESET;
    logic [11:0]       col_pos   = '0;
    logic [11:0]       row_pos   = '0;
    logic [MASS_W-1:0] mass_acc  = '0;
    logic [MOM_W-1:0]  xmom_acc  = '0;
    logic [MOM_W-1:0]  ymom_acc  = '0;

    int  mismatches   = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  hold_req     = 1'b0;
    bit  hold_done    = 1'b0;
    bit  no_idle      = 1'b0;

    intensity_weighted_centroid #(
        .MAX_WIDTH  (MAX_COLS),
        .MAX_HEIGHT (MAX_ROWS),
        .FRAC_BITS  (FRAC)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_pixel     (in_pixel),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_result    (out_result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [COORD_W-1:0] scaled_mean(logic [MOM_W-1:0] moment,
                                                       logic [MASS_W-1:0] mass);
        logic [63:0] q;
        q = (64'(moment) << FRAC) / 64'(mass);
        return (q > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : q[COORD_W-1:0];
    endfunction

    task automatic accumulate_pixel(t_pixel p);
        logic [63:0] sum;
        logic [12:0] eff_width;
        logic [12:0] next_col;
        t_result     res;
        eff_width = (width_cfg == 0) ? 13'd1 :
                    (width_cfg > MAX_COLS) ? 13'(MAX_COLS) : width_cfg;
        sum      = 64'(mass_acc) + 64'(p.pixel_value);
        mass_acc = (sum > MASS_MAX) ? MASS_MAX[MASS_W-1:0] : sum[MASS_W-1:0];
        sum      = 64'(xmom_acc) + 64'(p.pixel_value) * 64'(col_pos);
        xmom_acc = (sum > MOM_MAX) ? MOM_MAX[MOM_W-1:0] : sum[MOM_W-1:0];
        sum      = 64'(ymom_acc) + 64'(p.pixel_value) * 64'(row_pos);
        ymom_acc = (sum > MOM_MAX) ? MOM_MAX[MOM_W-1:0] : sum[MOM_W-1:0];
        // column wraps even when a narrower width arrived mid-frame
        next_col = 13'(col_pos) + 13'd1;
        if (next_col >= eff_width) begin
            col_pos = '0;
            if (row_pos < MAX_ROWS - 1)
                row_pos = row_pos + 12'd1;
        end else begin
            col_pos = next_col[11:0];
        end
        if (p.last_pixel) begin
            if (mass_acc == 0) begin
                res = '{center_x: '0, center_y: '0, empty_frame: 1'b1};
            end else begin
                res.center_x    = scaled_mean(xmom_acc, mass_acc);
                res.center_y    = scaled_mean(ymom_acc, mass_acc);
                res.empty_frame = 1'b0;
            end
            expected_centroids.push_back(res);
            col_pos  = '0;
            row_pos  = '0;
            mass_acc = '0;
            xmom_acc = '0;
            ymom_acc = '0;
        end
    endtask

    task automatic check_centroid(t_result got);
        t_result want;
        if (expected_centroids.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: x=%0d y=%0d empty=%0d",
                         got.center_x, got.center_y, got.empty_frame);
        end else begin
            want = expected_centroids.pop_front();
            if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
                got.empty_frame !== want.empty_frame) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d mismatch: expected x=%0d y=%0d empty=%0d,",
                             results_seen, want.center_x, want.center_y,
                             want.empty_frame,
                             " got x=%0d y=%0d empty=%0d",
                             got.center_x, got.center_y, got.empty_frame);
            end
        end
    endtask

    // pixel driver
    always @(posedge clk) begin : pixel_driver
        bit taken;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && !in_stall;
            if (taken)
                accumulate_pixel(in_pixel);
            if (!in_valid || taken) begin
                if (pending_pixels.size() > 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    in_pixel <= pending_pixels.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output back-pressure
    always @(posedge clk) begin : result_monitor
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                check_centroid(out_result);
                results_seen++;
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic void push_pixel(logic [PIX_W-1:0] value, logic last);
        pending_pixels.push_back('{pixel_value: value, last_pixel: last});
    endfunction

    task automatic wait_quiet();
        do @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_centroids.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(logic [CFG_W-1:0] value);
        wait_quiet();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        width_cfg  = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return '0;
        if (r < 10) return 13'd1;
        if (r < 14) return 13'(MAX_COLS);
        if (r < 18) return '1;
        if (r < 28) return 13'($urandom_range(8191));
        return 13'($urandom_range(16, 2));
    endfunction

    // random frame; returns the number of pixels queued
    function automatic int push_frame(int len, bit close);
        int  r;
        bit  dark;
        logic [PIX_W-1:0] v;
        dark = ($urandom_range(99) < 8);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (dark || r < 15) v = '0;
            else if (r < 25)    v = '1;
            else                v = PIX_W'($urandom_range(255));
            push_pixel(v, close && (i == len - 1));
        end
        return len;
    endfunction

    initial begin : stimulus
        int sent;
        int nframes;
        int len;
        int r;
        int phase;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // default width: empty single pixel, bright single pixel, offset pixel
        push_pixel(8'd0, 1'b1);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b1);

        // narrow rows so the row counter moves
        write_width(13'd4);
        for (int i = 0; i < 8; i++)
            push_pixel(8'd255, i == 7);

        // zero width behaves as one column
        write_width(13'd0);
        push_pixel(8'd10, 1'b0);
        push_pixel(8'd20, 1'b0);
        push_pixel(8'd30, 1'b1);

        // width above the maximum clamps
        write_width(13'h1FFF);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd128, 1'b1);

        // shrink the width while a frame is open
        write_width(13'(MAX_COLS));
        for (int i = 1; i <= 5; i++)
            push_pixel(8'(i), 1'b0);
        write_width(13'd2);
        push_pixel(8'd7, 1'b0);
        push_pixel(8'd8, 1'b0);
        push_pixel(8'd9, 1'b1);

        // many tiny frames while the output holds off, so the input backs up
        write_width(13'd3);
        hold_req = 1'b1;
        for (int f = 0; f < 16; f++)
            void'(push_frame($urandom_range(3, 1), 1'b1));

        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            write_width(pick_width());
            no_idle = (phase == 3);
            nframes = $urandom_range(6, 1);
            for (int f = 0; f < nframes; f++) begin
                r = $urandom_range(99);
                if (r < 80)      len = $urandom_range(12, 1);
                else if (r < 95) len = $urandom_range(64, 13);
                else             len = $urandom_range(300, 65);
                // sometimes leave the frame open across a width change
                sent += push_frame(len, !(f == nframes - 1 && $urandom_range(99) < 15));
            end
            phase++;
        end
        no_idle = 1'b0;

        wait_quiet();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
